@@ design/cama_pkg.sv @@
// Shared types and constants for the centered magnitude moving average.
// Used by the cell modules, the top level and the checker; depends on nothing.
package cama_pkg;

  // Configuration port geometry: one register at byte address 0.
  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W     = 3;
  localparam int WLEN_W     = 6;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd5;

  // Register index as seen on the word-address bit of paddr.
  localparam logic REG_WINDOW = 1'b0;

  // Control of the magnitude cell row for one cycle.
  typedef struct packed {
    logic shift;
    logic clear;
  } cama_chain_ctl_t;

  // Handshake-side tag that travels with a divider beat.
  typedef struct packed {
    logic valid;
    logic last;
  } cama_beat_t;

endpackage

@@ design/cama_mag_cell.sv @@
// One cell of the magnitude delay row: holds one sample magnitude and its valid flag.
// Depends on cama_pkg for the row control struct.
module cama_mag_cell
  import cama_pkg::*;
#(
  parameter int MAX_WINDOW = 32,
  parameter int MAG_W      = 16,
  parameter int WIN_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cama_chain_ctl_t       ctl,
  input  logic [WIN_W-1:0]      window,
  input  logic [MAG_W-1:0]      new_mag,
  input  logic [MAG_W-1:0]      prev_mag,
  input  logic                  prev_valid,
  output logic [MAG_W-1:0]      mag,
  output logic                  valid
);

  logic head;

  // The newest sample enters at cell MAX_WINDOW - window, so it reaches the
  // end of the row after exactly window - 1 further shifts.
  assign head = ((WIN_W+1)'(INDEX) + {1'b0, window}) == (WIN_W+1)'(MAX_WINDOW);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= head ? 1'b1 : prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      mag <= head ? new_mag : prev_mag;
    end
  end

endmodule

@@ design/cama_div_cell.sv @@
// One cell of the divider row: produces one quotient bit by restoring division.
// Depends on cama_pkg for the beat tag struct.
module cama_div_cell
  import cama_pkg::*;
#(
  parameter int N_W = 21,
  parameter int D_W = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [D_W-1:0]  divisor,
  input  cama_beat_t      in_tag,
  input  logic [D_W-1:0]  in_rem,
  input  logic [N_W-1:0]  in_nq,
  output cama_beat_t      out_tag,
  output logic [D_W-1:0]  out_rem,
  output logic [N_W-1:0]  out_nq
);

  logic [D_W:0] trial;
  logic [D_W:0] diff;
  logic         fits;

  // in_nq holds the dividend bits still to come in its upper part and the
  // quotient bits found so far in its lower part.
  assign trial = {in_rem, in_nq[N_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag.valid <= 1'b0;
    end else if (en) begin
      out_tag.valid <= in_tag.valid;
    end
    if (en) begin
      out_tag.last <= in_tag.last;
      out_rem      <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
      out_nq       <= {in_nq[N_W-2:0], fits};
    end
  end

endmodule

@@ design/centered_abs_moving_average_core.sv @@
// Centered moving average of sample magnitudes over a configurable window.
// Pipeline: a magnitude register, the window sum stage and the divider row of one quotient
// bit per cell, whose last cell is the output register.
// Throughput: one beat per cycle while m_tready does not stall the output; after a beat with
// tlast no input is taken until that beat and its flush have passed the window sum stage.
// Reset (synchronous, rst high) empties the pipeline and the stream; window_length = 5.
module centered_abs_moving_average_core
  import cama_pkg::*;
#(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // s_tdata: sample [SAMPLE_BITS-1:0], zero padding above
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
  input  logic                                   s_tlast,
  // m_tdata: average [SAMPLE_BITS-1:0], zero padding above
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
  output logic                                   m_tlast,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ADDR_W-1:0]                      paddr,
  input  logic [CFG_DATA_W-1:0]                  pwdata,
  output logic [CFG_DATA_W-1:0]                  prdata,
  output logic                                   pready
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int MAG_W  = SAMPLE_BITS;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);

  function automatic logic [WIN_W-1:0] clamp_window(input logic [WLEN_W-1:0] v);
    if (v == '0) begin
      return WIN_W'(1);
    end else if (32'(v) > 32'(MAX_WINDOW)) begin
      return WIN_W'(MAX_WINDOW);
    end else begin
      return WIN_W'(v);
    end
  endfunction

  // Configuration register.
  logic [WLEN_W-1:0] window_length;
  logic [WIN_W-1:0]  window;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_WINDOW);
  assign prdata = (paddr[ADDR_W-1] == REG_WINDOW) ? CFG_DATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
      window        <= clamp_window(WLEN_RESET);
    end else if (cfg_wr) begin
      window_length <= pwdata[WLEN_W-1:0];
      window        <= clamp_window(pwdata[WLEN_W-1:0]);
    end
  end

  logic [WIN_W-1:0] right;
  assign right = (window - WIN_W'(1)) >> 1;

  // Whole pipeline advances together; the last divider cell is the output register.
  cama_beat_t       div_tag [SUM_W+1];
  logic [WIN_W-1:0] div_rem [SUM_W+1];
  logic [SUM_W-1:0] div_nq  [SUM_W+1];
  logic             en;

  assign m_tvalid = div_tag[SUM_W].valid;
  assign m_tlast  = div_tag[SUM_W].last;
  assign m_tdata  = DATA_W'(div_nq[SUM_W][SAMPLE_BITS-1:0]);
  assign en       = !m_tvalid || m_tready;

  // Magnitude stage.
  logic [MAG_W-1:0] mag_in;
  logic [MAG_W-1:0] mag_r;
  logic             mag_valid;
  logic             mag_last;
  logic             flushing;
  logic             s_accept;

  assign mag_in   = s_tdata[SAMPLE_BITS-1] ? (~s_tdata[SAMPLE_BITS-1:0] + MAG_W'(1))
                                           : s_tdata[SAMPLE_BITS-1:0];
  assign s_tready = en && !flushing && !(mag_valid && mag_last);
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (en) begin
      mag_valid <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      mag_r    <= mag_in;
      mag_last <= s_tlast;
    end
  end

  // Window sum stage. A flush step behaves as a zero sample entering the window.
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [WIN_W-1:0] count;
  logic [WIN_W-1:0] count_next;
  logic [WIN_W-1:0] flush_cnt;
  logic [MAG_W-1:0] step_mag;
  logic [MAG_W-1:0] leave_mag;
  logic             step;
  logic             final_step;
  logic             start_flush;
  logic             emit;
  logic             stage_valid;
  logic             stage_last;
  logic [SUM_W-1:0] stage_sum;

  logic [MAG_W-1:0] cell_mag   [MAX_WINDOW];
  logic             cell_valid [MAX_WINDOW];
  cama_chain_ctl_t  chain_ctl;

  assign step        = en && (mag_valid || flushing);
  assign step_mag    = flushing ? '0 : mag_r;
  assign final_step  = flushing ? (flush_cnt == WIN_W'(1)) : (mag_last && right == '0);
  assign start_flush = !flushing && mag_last && right != '0;
  assign leave_mag   = cell_valid[MAX_WINDOW-1] ? cell_mag[MAX_WINDOW-1] : '0;
  assign sum_next    = sum - SUM_W'(leave_mag) + SUM_W'(step_mag);
  assign count_next  = (count == WIN_W'(MAX_WINDOW)) ? count : count + WIN_W'(1);
  assign emit        = count_next > right;

  assign chain_ctl.shift = step && !final_step;
  assign chain_ctl.clear = cfg_wr || (step && final_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum         <= '0;
      count       <= '0;
      flushing    <= 1'b0;
      flush_cnt   <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        sum      <= '0;
        count    <= '0;
        flushing <= 1'b0;
      end else if (step) begin
        if (final_step) begin
          sum      <= '0;
          count    <= '0;
          flushing <= 1'b0;
        end else begin
          sum   <= sum_next;
          count <= count_next;
          if (start_flush) begin
            flushing  <= 1'b1;
            flush_cnt <= right;
          end else if (flushing) begin
            flush_cnt <= flush_cnt - WIN_W'(1);
          end
        end
      end
      if (en) begin
        stage_valid <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_last <= final_step;
      stage_sum  <= sum_next;
    end
  end

  assign div_tag[0] = {stage_valid, stage_last};
  assign div_nq[0]  = stage_sum;
  assign div_rem[0] = '0;

  // Row of magnitude cells; the last cell holds the sample that leaves the window.
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_mag
    logic [MAG_W-1:0] prev_mag;
    logic             prev_valid;
    if (k == 0) begin : g_first
      assign prev_mag   = '0;
      assign prev_valid = 1'b0;
    end else begin : g_rest
      assign prev_mag   = cell_mag[k-1];
      assign prev_valid = cell_valid[k-1];
    end
    cama_mag_cell #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAG_W      (MAG_W),
      .WIN_W      (WIN_W),
      .INDEX      (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (chain_ctl),
      .window     (window),
      .new_mag    (step_mag),
      .prev_mag   (prev_mag),
      .prev_valid (prev_valid),
      .mag        (cell_mag[k]),
      .valid      (cell_valid[k])
    );
  end

  // Row of divider cells, most significant quotient bit first.
  for (genvar k = 0; k < SUM_W; k++) begin : g_div
    cama_div_cell #(
      .N_W (SUM_W),
      .D_W (WIN_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor (window),
      .in_tag  (div_tag[k]),
      .in_rem  (div_rem[k]),
      .in_nq   (div_nq[k]),
      .out_tag (div_tag[k+1]),
      .out_rem (div_rem[k+1]),
      .out_nq  (div_nq[k+1])
    );
  end

endmodule

@@ design/cama_checker.sv @@
// Port-level assertions for centered_abs_moving_average_core, with its bind.
// Depends on cama_pkg for the configuration port constants.
module cama_checker
  import cama_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic                                 s_tlast,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
  input logic                                 m_tlast,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [ADDR_W-1:0]                    paddr,
  input logic [CFG_DATA_W-1:0]                pwdata,
  input logic [CFG_DATA_W-1:0]                prdata
);

  localparam logic [SAMPLE_BITS-1:0] AVG_MAX = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat offered right after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  // A mean of magnitudes never exceeds the largest magnitude.
  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[SAMPLE_BITS-1:0] <= AVG_MAX)
    else $error("average above the largest sample magnitude");

  // A closing input beat holds off the next input beat, also when no flush follows it.
  a_flush_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after the closing beat");

  // A window write reads back.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[ADDR_W-1] == REG_WINDOW)
    |=> (paddr[ADDR_W-1] != REG_WINDOW) || (prdata[WLEN_W-1:0] == $past(pwdata[WLEN_W-1:0])))
    else $error("window_length did not take the written value");

endmodule

bind centered_abs_moving_average_core cama_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cama_checker (.*);
